>>> hw/rtl/ntc_pkg.sv
// shared constants and types for the thermistor converter
`default_nettype none
package ntc_pkg;
  localparam int unsigned MaxEntries   = 64;
  localparam int unsigned AdcFullScale = 32767;
  localparam logic [15:0] SeriesReset  = 16'd4750;
  localparam logic [6:0]  LengthReset  = 7'd64;

  localparam logic [1:0] CfgLenFirst  = 2'd0;
  localparam logic [1:0] CfgLenSecond = 2'd1;
  localparam logic [1:0] CfgSeries    = 2'd2;

  localparam logic ActLoad    = 1'b0;
  localparam logic ActConvert = 1'b1;

  localparam logic [1:0] StInterp    = 2'd0;
  localparam logic [1:0] StClampLo   = 2'd1;
  localparam logic [1:0] StClampHi   = 2'd2;
  localparam logic [1:0] StFullScale = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDIV,
    S_RD_FIRST,
    S_RD_LAST,
    S_CHK_LAST,
    S_SEARCH,
    S_SEARCH_CHK,
    S_RD_C,
    S_RD_C_WAIT,
    S_MUL,
    S_TDIV,
    S_FIN,
    S_OUT
  } state_t;
endpackage
`default_nettype wire

>>> hw/rtl/ntc_resistance_to_temperature_unit.sv
// thermistor resistance-to-temperature converter, top level
// Usage:
//  in_ channel: one beat per item; in_action 0 loads one table entry
//  (no result), 1 converts in_adc_sample with table in_table_select.
//  out_ channel: one beat per convert item with resistance, temperature
//  and status. cfg_ channel writes length registers and series resistor.
//  A load writes the entry and the next beat can follow at once. A convert
//  runs the resistance division, reads and checks the first and last
//  entries, runs a binary search (up to 6 probes for 64 entries), reads
//  the bracketing pair, runs the signed temperature division and
//  finishes. A clamped result leaves after the entry checks, and a
//  full-scale sample skips the resistance division. A new item is taken
//  the cycle after the result beat leaves. Reset sets the length and
//  series registers to their defaults and the controller to idle; table
//  contents stay undefined until loaded. While the receiver stalls the
//  result is held in the output register and the next item waits.
`default_nettype none
module ntc_resistance_to_temperature_unit #(
  parameter int unsigned MAX_ENTRIES    = ntc_pkg::MaxEntries,
  parameter int unsigned ADC_FULL_SCALE = ntc_pkg::AdcFullScale
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_action,
  input  wire logic        in_table_select,
  input  wire logic [5:0]  in_entry_index,
  input  wire logic [31:0] in_entry_resistance,
  input  wire logic signed [15:0] in_entry_temperature,
  input  wire logic [14:0] in_adc_sample,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_resistance,
  output logic signed [15:0] out_temperature,
  output logic [1:0]       out_status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int AW = IW + 1;
  localparam int LW = $clog2(MAX_ENTRIES + 1);
  localparam logic [16:0] FS = 17'(ADC_FULL_SCALE);

  logic [31:0] rmem [2*MAX_ENTRIES];
  logic [15:0] tmem [2*MAX_ENTRIES];
  logic [AW-1:0] raddr;
  logic [31:0] rdat_r;
  logic signed [15:0] tdat_r;

  logic [6:0] len0_r, len1_r;
  logic [15:0] series_r;
  ntc_pkg::state_t st_r, st_nxt;

  logic sel_r;
  logic [IW-1:0] a_r, b_r, c_r;
  logic [31:0] r_r;
  logic [31:0] ra_r, rc_r;
  logic signed [15:0] ta_r, tc_r;
  // shared shift-subtract divider: remainder, quotient, divisor, count
  logic [63:0] rem_r;
  logic [63:0] quo_r;
  logic [63:0] dvs_r;
  logic [6:0] cnt_r;
  logic neg_r;
  logic ovf_r;

  // clamp length
  logic [6:0] len_raw;
  logic [LW-1:0] n_use;
  always_comb begin
    len_raw = sel_r ? len1_r : len0_r;
    if (len_raw < 7'd2) n_use = LW'(2);
    else if (32'(len_raw) > MAX_ENTRIES) n_use = LW'(MAX_ENTRIES);
    else n_use = LW'(len_raw);
  end

  assign in_ready  = (st_r == ntc_pkg::S_IDLE) && !out_valid;
  assign cfg_ready = 1'b1;
  wire in_fire = in_valid && in_ready;

  // memories
  always_ff @(posedge clk) begin
    if (in_fire && in_action == ntc_pkg::ActLoad && 32'(in_entry_index) < MAX_ENTRIES) begin
      rmem[{in_table_select, IW'(in_entry_index)}] <= in_entry_resistance;
      tmem[{in_table_select, IW'(in_entry_index)}] <= in_entry_temperature;
    end
    rdat_r <= rmem[raddr];
    tdat_r <= tmem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len0_r <= ntc_pkg::LengthReset;
      len1_r <= ntc_pkg::LengthReset;
      series_r <= ntc_pkg::SeriesReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ntc_pkg::CfgLenFirst:  len0_r <= cfg_data[6:0];
        ntc_pkg::CfgLenSecond: len1_r <= cfg_data[6:0];
        ntc_pkg::CfgSeries:    series_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  logic [IW-1:0] last;
  assign last = IW'(n_use - LW'(1));
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ntc_pkg::S_IDLE:
        if (in_fire && in_action == ntc_pkg::ActConvert) begin
          st_nxt = ({2'b0, in_adc_sample} >= FS) ? ntc_pkg::S_RD_FIRST : ntc_pkg::S_RDIV;
        end
      ntc_pkg::S_RDIV:      if (cnt_r == 7'd0) st_nxt = ntc_pkg::S_RD_FIRST;
      ntc_pkg::S_RD_FIRST:  st_nxt = ntc_pkg::S_RD_LAST;
      ntc_pkg::S_RD_LAST:   st_nxt = ovf_r ? ntc_pkg::S_OUT :
                                     (r_r >= rdat_r) ? ntc_pkg::S_OUT : ntc_pkg::S_CHK_LAST;
      ntc_pkg::S_CHK_LAST:  st_nxt = (r_r <= rdat_r) ? ntc_pkg::S_OUT : ntc_pkg::S_SEARCH;
      ntc_pkg::S_SEARCH:    st_nxt = (a_r < b_r && b_r < c_r) ? ntc_pkg::S_SEARCH_CHK
                                                               : ntc_pkg::S_RD_C;
      ntc_pkg::S_SEARCH_CHK: st_nxt = ntc_pkg::S_SEARCH;
      ntc_pkg::S_RD_C:      st_nxt = ntc_pkg::S_RD_C_WAIT;
      ntc_pkg::S_RD_C_WAIT: st_nxt = ntc_pkg::S_MUL;
      ntc_pkg::S_MUL:       st_nxt = ntc_pkg::S_TDIV;
      ntc_pkg::S_TDIV:      if (cnt_r == 7'd0) st_nxt = ntc_pkg::S_FIN;
      ntc_pkg::S_FIN:       st_nxt = ntc_pkg::S_OUT;
      ntc_pkg::S_OUT:       st_nxt = ntc_pkg::S_IDLE;
      default:              st_nxt = ntc_pkg::S_IDLE;
    endcase
  end

  // read address
  always_comb begin
    unique case (st_r)
      ntc_pkg::S_RD_LAST:    raddr = {sel_r, last};
      ntc_pkg::S_SEARCH:     raddr = {sel_r, b_r};
      ntc_pkg::S_RD_C:       raddr = {sel_r, a_r};
      ntc_pkg::S_RD_C_WAIT:  raddr = {sel_r, c_r};
      default:               raddr = {sel_r, IW'(0)};
    endcase
  end

  logic [64:0] trial;
  assign trial = {rem_r, quo_r[63]} - {1'b0, dvs_r};
  logic [31:0] den;
  logic signed [33:0] num;
  logic signed [16:0] dt;
  logic signed [49:0] prod;
  logic signed [33:0] tq;
  logic signed [34:0] tsum;
  assign den = ra_r - rc_r;
  assign num = $signed({2'b0, ra_r}) - $signed({2'b0, r_r});
  assign dt  = 17'(tc_r) - 17'(ta_r);
  assign prod = 50'(num) * 50'(dt);
  assign tq = neg_r ? -$signed(34'(quo_r)) : $signed(34'(quo_r));
  assign tsum = 35'(ta_r) + 35'(tq);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ntc_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ntc_pkg::S_OUT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      ntc_pkg::S_IDLE: if (in_fire) begin
        sel_r <= in_table_select;
        ovf_r <= ({2'b0, in_adc_sample} >= FS);
        rem_r <= '0;
        quo_r <= 64'({16'b0, 32'(series_r) * 32'(in_adc_sample)}) << 32;
        dvs_r <= 64'(FS - {2'b0, in_adc_sample});
        cnt_r <= 7'd32;
        r_r <= 32'hFFFF_FFFF;
        out_status <= ntc_pkg::StFullScale;
      end
      ntc_pkg::S_RDIV: if (cnt_r != 0) begin
        if (!trial[64]) begin
          rem_r <= trial[63:0];
          quo_r <= {quo_r[62:0], 1'b1};
        end else begin
          rem_r <= {rem_r[62:0], quo_r[63]};
          quo_r <= {quo_r[62:0], 1'b0};
        end
        cnt_r <= cnt_r - 7'd1;
      end else begin
        // 32 steps over a 32-bit dividend: quotient fits 32 bits
        r_r <= quo_r[31:0];
      end
      ntc_pkg::S_RD_LAST: begin
        ra_r <= rdat_r;
        out_temperature <= tdat_r;
        if (!ovf_r && r_r >= rdat_r) out_status <= ntc_pkg::StClampLo;
      end
      ntc_pkg::S_CHK_LAST: begin
        out_temperature <= tdat_r;
        out_status <= ntc_pkg::StClampHi;
        a_r <= '0;
        c_r <= last;
        b_r <= IW'(n_use >> 1);
      end
      ntc_pkg::S_SEARCH_CHK: begin
        if (r_r >= rdat_r) begin
          c_r <= b_r;
          b_r <= IW'(({1'b0, a_r} + {1'b0, b_r}) >> 1);
        end else begin
          a_r <= b_r;
          b_r <= IW'(({1'b0, b_r} + {1'b0, c_r}) >> 1);
        end
      end
      ntc_pkg::S_RD_C_WAIT: begin
        ra_r <= rdat_r;
        ta_r <= tdat_r;
      end
      ntc_pkg::S_MUL: begin
        rc_r <= rdat_r;
        tc_r <= tdat_r;
      end
      ntc_pkg::S_TDIV: begin
        if (cnt_r == 7'd49) begin
          // magnitude is below 2^48: 48 steps over the top 48 bits
          neg_r <= prod[49];
          quo_r <= 64'(prod[49] ? -prod : prod) << 16;
          rem_r <= '0;
          dvs_r <= 64'(den);
          cnt_r <= 7'd48;
        end else if (cnt_r != 0) begin
          if (!trial[64]) begin
            rem_r <= trial[63:0];
            quo_r <= {quo_r[62:0], 1'b1};
          end else begin
            rem_r <= {rem_r[62:0], quo_r[63]};
            quo_r <= {quo_r[62:0], 1'b0};
          end
          cnt_r <= cnt_r - 7'd1;
        end
      end
      ntc_pkg::S_FIN: begin
        out_status <= ntc_pkg::StInterp;
        if (den == 32'd0) out_temperature <= ta_r;
        else if (tsum > 35'sd32767) out_temperature <= 16'sh7FFF;
        else if (tsum < -35'sd32768) out_temperature <= 16'sh8000;
        else out_temperature <= tsum[15:0];
      end
      default: ;
    endcase
    if (st_r == ntc_pkg::S_RD_FIRST) out_temperature <= tdat_r;
    if (st_r == ntc_pkg::S_MUL) cnt_r <= 7'd49;
  end

  assign out_resistance = r_r;

  // assertions
  a_noaccept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ntc_pkg::S_IDLE) |-> !in_ready) else $error("accept while busy");
  a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ntc_pkg::S_OUT) |=> out_valid) else $error("result lost");
  a_search_order: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ntc_pkg::S_RD_C) |-> (a_r < c_r)) else $error("bad bracket");
endmodule
`default_nettype wire
